[src/pva_pkg.sv]
`default_nettype none

package pva_pkg;

    localparam int NUM_VOICES_DEF = 32;
    localparam int PRIO_W         = 32;

    // Starting value of the lowest-priority search
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

    typedef enum logic [1:0] {
        REQ_ALLOC       = 2'd0,
        REQ_RELEASE     = 2'd1,
        REQ_SET_PRIO    = 2'd2,
        REQ_RELEASE_ALL = 2'd3
    } t_req;

    // Operation broadcast from the controller to every cell
    typedef enum logic [2:0] {
        COP_NOP,
        COP_FREE,
        COP_OCCUPY,
        COP_SET_PRIO,
        COP_FREE_ALL
    } t_cop;

    typedef struct packed {
        t_cop                     op;
        logic signed [PRIO_W-1:0] prio;
    } t_cmd;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                     active;
        logic                     found;
        logic signed [PRIO_W-1:0] low_prio;
    } t_scan;

endpackage

`default_nettype wire

[src/pva_if.sv]
`default_nettype none

interface pva_in_if
    import pva_pkg::*;
#(
    parameter int IDX_W = 5
);
    logic                     valid;
    logic                     ready;
    t_req                     req_type;
    logic signed [PRIO_W-1:0] priority_req;
    logic [IDX_W-1:0]         slot_index;

    modport source (output valid, output req_type, output priority_req,
                    output slot_index, input ready);
    modport sink   (input valid, input req_type, input priority_req,
                    input slot_index, output ready);
endinterface

interface pva_out_if #(
    parameter int SLOT_W = 6
);
    logic              valid;
    logic              ready;
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic              was_busy;

    modport source (output valid, output granted, output slot, output evicted,
                    output was_busy, input ready);
    modport sink   (input valid, input granted, input slot, input evicted,
                    input was_busy, output ready);
endinterface

`default_nettype wire

[src/priority_voice_allocator_unit.sv]
`default_nettype none

// Priority voice allocator. Each voice slot lives in a cell of a row; a search
// token walks the row one cell per clock, so an allocate passes through the
// launch state, then the search state until the token leaves the register of
// the last cell, then the finishing state, where its result is loaded into the
// output register. Release, set-priority and release-all skip the search and
// go straight from acceptance to the finishing state. One request is in flight
// at a time; the next is accepted in the cycle after the result is loaded,
// while that result may
// still wait in the output register. A result that cannot leave because the
// previous one is still waiting holds the block in its finishing cycle.
// Allocate grants the lowest free slot; with all slots busy it evicts the
// lowest-priority slot (first on ties) if strictly below the request, otherwise
// denies and reports slot NUM_VOICES. No clearing pass is needed after reset:
// every cell resets to free with priority zero.

module priority_voice_allocator_unit
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pva_in_if.sink      i_req,
    pva_out_if.source   o_res
);

    localparam int IDX_W  = $clog2(NUM_VOICES);
    localparam int SLOT_W = $clog2(NUM_VOICES + 1);
    localparam int CMP_W  = IDX_W + 1;

    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(NUM_VOICES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;

    // Captured request
    t_req                     r_req;
    logic signed [PRIO_W-1:0] r_prio;
    logic [IDX_W-1:0]         r_idx;

    // Search outcome
    logic                     r_found;
    logic signed [PRIO_W-1:0] r_low_prio;
    logic [IDX_W-1:0]         r_sel;

    // Output register
    logic              r_out_valid;
    logic              r_granted;
    logic [SLOT_W-1:0] r_slot;
    logic              r_evicted;
    logic              r_was_busy;

    // Cell chain
    t_scan              scan     [NUM_VOICES+1];
    logic [IDX_W-1:0]   scan_idx [NUM_VOICES+1];
    logic [NUM_VOICES-1:0] busy_vec;

    t_cmd             cmd;
    logic [IDX_W-1:0] cmd_idx;

    logic              out_free;
    logic              finish;
    logic              idx_ok;
    logic              n_granted;
    logic [SLOT_W-1:0] n_slot;
    logic              n_evicted;
    logic              n_was_busy;

    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;
    assign finish      = (r_state == S_FINISH) && out_free;
    assign idx_ok      = (CMP_W'(r_idx) < CMP_W'(NUM_VOICES));

    // Launch the token into the first cell
    assign scan[0].active   = (r_state == S_LAUNCH);
    assign scan[0].found    = 1'b0;
    assign scan[0].low_prio = PRIO_MAX;
    assign scan_idx[0]      = '0;

    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
        pva_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_cmd_idx  (cmd_idx),
            .i_scan     (scan[g]),
            .i_scan_idx (scan_idx[g]),
            .o_scan     (scan[g+1]),
            .o_scan_idx (scan_idx[g+1]),
            .o_busy     (busy_vec[g])
        );
    end

    // Decide the result and the cell update in the finishing cycle
    always_comb begin
        cmd.op     = COP_NOP;
        cmd.prio   = r_prio;
        cmd_idx    = r_idx;
        n_granted  = 1'b0;
        n_slot     = SLOT_NONE;
        n_evicted  = 1'b0;
        n_was_busy = 1'b0;
        unique case (r_req)
            REQ_ALLOC: begin
                cmd_idx = r_sel;
                if (r_found) begin
                    cmd.op    = COP_OCCUPY;
                    n_granted = 1'b1;
                    n_slot    = SLOT_W'(r_sel);
                end else if (r_low_prio < r_prio) begin
                    // Steal: occupying overwrites the evicted slot outright
                    cmd.op    = COP_OCCUPY;
                    n_granted = 1'b1;
                    n_slot    = SLOT_W'(r_sel);
                    n_evicted = 1'b1;
                end
            end
            REQ_RELEASE: begin
                if (idx_ok) begin
                    cmd.op     = COP_FREE;
                    n_was_busy = busy_vec[r_idx];
                end
            end
            REQ_SET_PRIO: begin
                if (idx_ok) begin
                    cmd.op     = COP_SET_PRIO;
                    n_was_busy = busy_vec[r_idx];
                end
            end
            REQ_RELEASE_ALL: begin
                cmd.op = COP_FREE_ALL;
            end
            default: begin
            end
        endcase
        if (!finish) begin
            cmd.op = COP_NOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= (i_req.req_type == REQ_ALLOC) ? S_LAUNCH : S_FINISH;
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan[NUM_VOICES].active) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Hold the request while it is worked on
        if (i_req.valid && i_req.ready) begin
            r_req  <= i_req.req_type;
            r_prio <= i_req.priority_req;
            r_idx  <= i_req.slot_index;
        end
        // Catch the token as it leaves the last cell
        if (r_state == S_SCAN && scan[NUM_VOICES].active) begin
            r_found    <= scan[NUM_VOICES].found;
            r_low_prio <= scan[NUM_VOICES].low_prio;
            r_sel      <= scan_idx[NUM_VOICES];
        end
        if (finish) begin
            r_granted  <= n_granted;
            r_slot     <= n_slot;
            r_evicted  <= n_evicted;
            r_was_busy <= n_was_busy;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.granted  = r_granted;
    assign o_res.slot     = r_slot;
    assign o_res.evicted  = r_evicted;
    assign o_res.was_busy = r_was_busy;

    // A grant names a real slot; a refusal names none
    a_grant_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.granted ? (o_res.slot < SLOT_NONE) : (o_res.slot == SLOT_NONE)))
        else $error("slot does not agree with granted");

    a_evict_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.evicted |-> o_res.granted && !o_res.was_busy)
        else $error("eviction without grant");

    // The token only leaves the chain while a search is awaited
    a_token_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan[NUM_VOICES].active |-> (r_state == S_SCAN))
        else $error("search token outside search");

    // Cells are never written while a request is being searched
    a_quiet_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(busy_vec))
        else $error("slot table changed during search");

endmodule

`default_nettype wire

[src/pva_cell.sv]
`default_nettype none

module pva_cell
    import pva_pkg::*;
#(
    parameter int IDX_W   = 5,
    parameter int CELL_ID = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [IDX_W-1:0] i_cmd_idx,
    input  wire t_scan            i_scan,
    input  wire logic [IDX_W-1:0] i_scan_idx,
    output      t_scan            o_scan,
    output      logic [IDX_W-1:0] o_scan_idx,
    output      logic             o_busy
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic                     r_busy, n_busy;
    logic signed [PRIO_W-1:0] r_prio, n_prio;
    logic                     r_scan_act;
    logic                     r_scan_found;
    logic signed [PRIO_W-1:0] r_scan_low;
    logic [IDX_W-1:0]         r_scan_idx;
    t_scan                    n_scan;
    logic [IDX_W-1:0]         n_scan_idx;
    logic                     hit;

    assign hit = (i_cmd_idx == MY_IDX);

    always_comb begin
        n_busy = r_busy;
        n_prio = r_prio;
        unique case (i_cmd.op)
            COP_NOP: begin
            end
            COP_FREE: begin
                if (hit) begin
                    n_busy = 1'b0;
                    n_prio = '0;
                end
            end
            COP_OCCUPY: begin
                if (hit) begin
                    n_busy = 1'b1;
                    n_prio = i_cmd.prio;
                end
            end
            COP_SET_PRIO: begin
                if (hit && r_busy) begin
                    n_prio = i_cmd.prio;
                end
            end
            COP_FREE_ALL: begin
                n_busy = 1'b0;
                n_prio = '0;
            end
            default: begin
            end
        endcase
    end

    // Pass the token on; claim it if free, or if lower than the best so far
    always_comb begin
        n_scan     = i_scan;
        n_scan_idx = i_scan_idx;
        if (i_scan.active && !i_scan.found) begin
            if (!r_busy) begin
                n_scan.found = 1'b1;
                n_scan_idx   = MY_IDX;
            end else if (r_prio < i_scan.low_prio) begin
                n_scan.low_prio = r_prio;
                n_scan_idx      = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_prio     <= '0;
            r_scan_act <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_prio     <= n_prio;
            r_scan_act <= n_scan.active;
        end
        r_scan_found <= n_scan.found;
        r_scan_low   <= n_scan.low_prio;
        r_scan_idx   <= n_scan_idx;
    end

    assign o_scan.active   = r_scan_act;
    assign o_scan.found    = r_scan_found;
    assign o_scan.low_prio = r_scan_low;
    assign o_scan_idx      = r_scan_idx;
    assign o_busy          = r_busy;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
    import pva_pkg::*;

    localparam int NUM            = NUM_VOICES_DEF;
    localparam int IDX_W          = 5;
    localparam int SLOT_W         = 6;
    // Long receiver hold-off used to back the block up
    localparam int HOLD_CYCLES    = 300;
    // Cycles with no handshake on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last result: longer than one allocate scan
    localparam int DRAIN_CYCLES   = 60;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic              was_busy;
    } t_voice_outcome;

    logic clk;
    logic rst_n;

    pva_in_if  #(.IDX_W(IDX_W))   req_if ();
    pva_out_if #(.SLOT_W(SLOT_W)) res_if ();

    priority_voice_allocator_unit #(
        .NUM_VOICES(NUM)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    // Shadow of the voice table
    bit [NUM-1:0]             voice_taken;
    logic signed [PRIO_W-1:0] voice_level [NUM];

    t_voice_outcome outcomes_due [$];
    int             fail_count;

    // Idling controls, set by the tests
    bit send_gaps;
    bit recv_stalls;
    bit hold_off_pending;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 9))
            0: return PRIO_MIN;
            1: return PRIO_MAX;
            2, 3, 4, 5: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // Apply one request to the shadow table and return the outcome it yields
    function automatic t_voice_outcome apply_voice_request(t_req rt,
                                                           logic signed [PRIO_W-1:0] p,
                                                           logic [IDX_W-1:0] idx);
        t_voice_outcome res;
        int found;
        int lowest_idx;
        logic signed [PRIO_W-1:0] lowest;
        res = '{granted: 1'b0, slot: SLOT_W'(NUM), evicted: 1'b0, was_busy: 1'b0};
        case (rt)
            REQ_ALLOC: begin
                found      = NUM;
                lowest     = PRIO_MAX;
                lowest_idx = 0;
                for (int i = 0; i < NUM; i++) begin
                    if (found == NUM) begin
                        if (!voice_taken[i])
                            found = i;
                        else if (voice_level[i] < lowest) begin
                            lowest     = voice_level[i];
                            lowest_idx = i;
                        end
                    end
                end
                // Steal the weakest voice only when it is strictly below the request
                if (found == NUM && lowest < p) begin
                    found       = lowest_idx;
                    res.evicted = 1'b1;
                end
                if (found < NUM) begin
                    voice_taken[found] = 1'b1;
                    voice_level[found] = p;
                    res.granted        = 1'b1;
                    res.slot           = SLOT_W'(found);
                end
            end
            REQ_RELEASE: begin
                if (int'(idx) < NUM) begin
                    res.was_busy     = voice_taken[idx];
                    voice_taken[idx] = 1'b0;
                    voice_level[idx] = '0;
                end
            end
            REQ_SET_PRIO: begin
                if (int'(idx) < NUM) begin
                    res.was_busy = voice_taken[idx];
                    // A free voice keeps priority zero
                    if (voice_taken[idx])
                        voice_level[idx] = p;
                end
            end
            default: begin
                voice_taken = '0;
                for (int i = 0; i < NUM; i++)
                    voice_level[i] = '0;
            end
        endcase
        return res;
    endfunction

    // Offer one item, hold it until taken, then record what it should yield
    task automatic send_item(t_req rt, logic signed [PRIO_W-1:0] p, logic [IDX_W-1:0] idx);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= rt;
        req_if.priority_req <= p;
        req_if.slot_index   <= idx;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        outcomes_due.push_back(apply_voice_request(rt, p, idx));
    endtask

    // Receiver side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
                stall = pick_gap() + 1;
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result taken with the oldest outcome due
    always @(posedge clk) begin
        t_voice_outcome want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (outcomes_due.size() == 0) begin
                $error("result with no outcome due: granted %0d slot %0d evicted %0d was_busy %0d",
                       res_if.granted, res_if.slot, res_if.evicted, res_if.was_busy);
                fail_count++;
            end else begin
                want = outcomes_due.pop_front();
                if (res_if.granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, res_if.granted);
                    fail_count++;
                end
                if (res_if.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, res_if.slot);
                    fail_count++;
                end
                if (res_if.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, res_if.evicted);
                    fail_count++;
                end
                if (res_if.was_busy !== want.was_busy) begin
                    $error("was_busy: expected %0d, got %0d", want.was_busy, res_if.was_busy);
                    fail_count++;
                end
            end
        end
    end

    // Abandon the run after a long stretch with no handshake at all
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Every operation on a near-empty table, free and busy slots, field extremes
    task automatic test_basic_ops();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_item(REQ_RELEASE_ALL, '0, '0);
        send_item(REQ_RELEASE, '0, 5'd0);
        send_item(REQ_SET_PRIO, PRIO_MAX, 5'd31);
        send_item(REQ_ALLOC, PRIO_MIN, 5'd0);
        send_item(REQ_ALLOC, PRIO_MAX, 5'd31);
        send_item(REQ_ALLOC, '0, 5'd0);
        send_item(REQ_SET_PRIO, PRIO_MAX, 5'd0);
        send_item(REQ_SET_PRIO, PRIO_MIN, 5'd1);
        send_item(REQ_RELEASE, PRIO_MAX, 5'd1);
        send_item(REQ_ALLOC, -32'sd1, 5'd31);
        send_item(REQ_RELEASE, '0, 5'd31);
        send_item(REQ_RELEASE, '0, 5'd1);
        send_item(REQ_RELEASE, '0, 5'd1);
        // Free slot: the new priority is dropped
        send_item(REQ_SET_PRIO, 32'sd5, 5'd1);
        send_item(REQ_ALLOC, 32'sd7, 5'd31);
        send_item(REQ_RELEASE_ALL, -32'sd1, 5'd31);
        send_item(REQ_SET_PRIO, 32'sd9, 5'd0);
        send_item(REQ_ALLOC, 32'h5555_5555, 5'd21);
    endtask

    // Fill the table, then deny, steal and break ties
    task automatic test_full_table();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_item(REQ_RELEASE_ALL, '0, '0);
        for (int i = 0; i < NUM; i++)
            send_item(REQ_ALLOC, $signed(32'($urandom_range(0, 4))) - 32'sd2, 5'($urandom));
        // Nothing is strictly below the minimum: deny
        send_item(REQ_ALLOC, PRIO_MIN, '0);
        send_item(REQ_ALLOC, -32'sd2, '0);
        repeat (4) send_item(REQ_ALLOC, PRIO_MAX, '0);
        for (int i = 0; i < NUM; i++)
            send_item(REQ_SET_PRIO, PRIO_MAX, 5'(i));
        // Every voice at the maximum: a tie with the request, so deny
        send_item(REQ_ALLOC, PRIO_MAX, '0);
        send_item(REQ_SET_PRIO, 32'sd3, 5'd17);
        send_item(REQ_SET_PRIO, 32'sd3, 5'd9);
        // Equal lowest priorities: the first index goes
        send_item(REQ_ALLOC, 32'sd4, '0);
        send_item(REQ_ALLOC, 32'sd4, '0);
        send_item(REQ_ALLOC, 32'sd4, '0);
        send_item(REQ_RELEASE_ALL, '0, '0);
    endtask

    // Hold the receiver off while items keep coming, so the block backs up
    task automatic test_back_pressure();
        send_gaps        = 1'b0;
        recv_stalls      = 1'b0;
        hold_off_pending = 1'b1;
        repeat (12) send_item(t_req'($urandom_range(0, 2)), pick_prio(), 5'($urandom));
    endtask

    // Mostly allocates, so the table fills and stealing is exercised often
    task automatic test_voice_traffic(int count, bit gaps, bit stalls);
        int r;
        t_req rt;
        send_gaps   = gaps;
        recv_stalls = stalls;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                rt = REQ_ALLOC;
            else if (r < 70)
                rt = REQ_RELEASE;
            else if (r < 98)
                rt = REQ_SET_PRIO;
            else
                rt = REQ_RELEASE_ALL;
            send_item(rt, pick_prio(), 5'($urandom));
        end
    endtask

    // Unweighted fields throughout
    task automatic test_noise(int count);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        repeat (count)
            send_item(t_req'($urandom_range(0, 3)), $signed(32'($urandom)), 5'($urandom));
    endtask

    initial begin
        fail_count       = 0;
        send_gaps        = 1'b0;
        recv_stalls      = 1'b0;
        hold_off_pending = 1'b0;
        voice_taken      = '0;
        for (int i = 0; i < NUM; i++)
            voice_level[i] = '0;

        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_ALLOC;
        req_if.priority_req <= '0;
        req_if.slot_index   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_table();
        test_back_pressure();
        test_voice_traffic(180, 1'b1, 1'b1);
        test_voice_traffic(120, 1'b0, 1'b0);
        test_voice_traffic(120, 1'b1, 1'b1);
        test_noise(40);

        req_if.valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
